// File: design/column_atlas_allocator_macros.svh
// Assertion helpers used by the allocator RTL
`ifndef COLUMN_ATLAS_ALLOCATOR_MACROS_SVH
`define COLUMN_ATLAS_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define CAA_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define CAA_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/caa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package caa_pkg;

  // Default payload widths
  localparam int COUNT_BITS_DEF = 16;
  localparam int COORD_BITS_DEF = 12;

  // Cursor position width (x texel and fill row)
  localparam int POS_BITS = 14;

  // Configuration register widths
  localparam int ATLAS_DIM_W = 13;
  localparam int ITEM_W      = 7;
  localparam int QLOG_W      = 3;
  localparam int QMASK_W     = (1 << QLOG_W) - 1;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_WIDTH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_LOG2 = 2'd3;

  // Configuration reset values
  localparam logic [ATLAS_DIM_W-1:0] ATLAS_WIDTH_RST  = 13'd512;
  localparam logic [ATLAS_DIM_W-1:0] ATLAS_HEIGHT_RST = 13'd512;
  localparam logic [ITEM_W-1:0]      ITEM_WIDTH_RST   = 7'd64;
  localparam logic [QLOG_W-1:0]      QUANTUM_LOG2_RST = 3'd3;

endpackage

`default_nettype wire

// File: design/caa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface caa_req_if #(
  parameter int COUNT_BITS = caa_pkg::COUNT_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] texel_count;

  modport source (output valid, output texel_count, input ready);
  modport sink   (input valid, input texel_count, output ready);
endinterface

`default_nettype wire

// File: design/caa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface caa_rsp_if #(
  parameter int COORD_BITS = caa_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] column_index;
  logic [COORD_BITS-1:0] row_slot;
  logic                  out_of_space;

  modport source (output valid, output column_index, output row_slot,
                  output out_of_space, input ready);
  modport sink   (input valid, input column_index, input row_slot,
                  input out_of_space, output ready);
endinterface

`default_nettype wire

// File: design/column_atlas_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                  Transfers when
// req      in   texel_count                              req.valid & req.ready
// rsp      out  column_index, row_slot, out_of_space     rsp.valid & rsp.ready
// cfg      in   cfg_index_i, cfg_data_i                  cfg_we_i
//
// A request passes through the divide, move and place steps; the bit-serial
// divider produces one quotient bit per cycle.
// Reset clears the column cursors and loads the register defaults.
// A finished response waits in the output register while a new request
// is accepted; a second result stalls in the final step until rsp drains.

module column_atlas_allocator #(
  parameter int COUNT_BITS = caa_pkg::COUNT_BITS_DEF,
  parameter int COORD_BITS = caa_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [caa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [caa_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  caa_req_if.sink                               req,
  caa_rsp_if.source                             rsp
);

`include "column_atlas_allocator_macros.svh"

  localparam int HW = COUNT_BITS + 1;
  localparam int PW = caa_pkg::POS_BITS;
  localparam int LW = PW + 1;
  localparam int SW = ((HW > LW) ? HW : LW) + 2;
  localparam int IW = caa_pkg::ITEM_W;
  localparam int QW = caa_pkg::QMASK_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DIV   = 2'd1;
  localparam logic [1:0] S_MOVE  = 2'd2;
  localparam logic [1:0] S_PLACE = 2'd3;

  // Configuration registers
  logic [caa_pkg::ATLAS_DIM_W-1:0] atlas_width_q;
  logic [caa_pkg::ATLAS_DIM_W-1:0] atlas_height_q;
  logic [IW-1:0]                   item_width_q;
  logic [caa_pkg::QLOG_W-1:0]      qlog_q;

  // Control and cursors
  logic [1:0]            state_q, state_d;
  logic [PW-1:0]         left_q;
  logic [PW-1:0]         fill_q;
  logic [COORD_BITS-1:0] col_q;

  // Candidate placement after a possible column move
  logic [LW-1:0]         cand_left_q, cand_left_d;
  logic [PW-1:0]         cand_fill_q, cand_fill_d;
  logic [COORD_BITS-1:0] cand_col_q, cand_col_d;

  // Output register
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_col_q;
  logic [COORD_BITS-1:0] out_row_q;
  logic                  out_oos_q;

  // Divider hookup
  logic          req_fire;
  logic          div_done;
  logic [HW-1:0] quot;
  logic [HW-1:0] dividend;

  // Placement math
  logic [SW-1:0]         fill_h;
  logic                  move;
  logic [SW-1:0]         cand_left_end;
  logic [SW-1:0]         cand_fill_h;
  logic                  fail;
  logic [QW-1:0]         qmask;
  logic [SW-1:0]         step;
  logic [SW-1:0]         fill_sum;
  logic [PW-1:0]         row_full;
  logic                  load;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state_q == S_IDLE);
  assign dividend  = HW'(req.texel_count) + HW'(item_width_q) - HW'(1);

  caa_div #(
    .DIVIDEND_W (HW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (req_fire),
    .dividend_i (dividend),
    .divisor_i  (item_width_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Take register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_width_q  <= caa_pkg::ATLAS_WIDTH_RST;
      atlas_height_q <= caa_pkg::ATLAS_HEIGHT_RST;
      item_width_q   <= caa_pkg::ITEM_WIDTH_RST;
      qlog_q         <= caa_pkg::QUANTUM_LOG2_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        caa_pkg::CFG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data_i;
        caa_pkg::CFG_ATLAS_HEIGHT: atlas_height_q <= cfg_data_i;
        caa_pkg::CFG_ITEM_WIDTH:   item_width_q   <= cfg_data_i[IW-1:0];
        caa_pkg::CFG_QUANTUM_LOG2: qlog_q         <= cfg_data_i[caa_pkg::QLOG_W-1:0];
        default: ;
      endcase
    end
  end

  // Decide whether the item spills into the next column
  always_comb begin
    fill_h      = SW'(fill_q) + SW'(quot);
    move        = (fill_h > SW'(atlas_height_q));
    cand_left_d = move ? (LW'(left_q) + LW'(item_width_q)) : LW'(left_q);
    cand_fill_d = move ? '0 : fill_q;
    cand_col_d  = move ? (col_q + COORD_BITS'(1)) : col_q;
  end

  // Check the candidate and compute the new fill level
  always_comb begin
    cand_left_end = SW'(cand_left_q) + SW'(item_width_q);
    cand_fill_h   = SW'(cand_fill_q) + SW'(quot);
    fail          = (item_width_q == '0) ||
                    (cand_left_end > SW'(atlas_width_q)) ||
                    (cand_fill_h > SW'(atlas_height_q));
    qmask         = ~({QW{1'b1}} << qlog_q);
    step          = (SW'(quot) + SW'(qmask)) & ~SW'(qmask);
    fill_sum      = SW'(cand_fill_q) + step;
    row_full      = cand_fill_q >> qlog_q;
    load          = (state_q == S_PLACE) && (!out_valid_q || rsp.ready);
  end

  // Sequence one request
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req_fire) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_MOVE;
      S_MOVE:  state_d = S_PLACE;
      S_PLACE: if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, cursors and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      left_q      <= '0;
      fill_q      <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load && !fail) begin
        left_q <= cand_left_q[PW-1:0];
        fill_q <= fill_sum[PW-1:0];
        col_q  <= cand_col_q;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch candidate and response payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_MOVE) begin
      cand_left_q <= cand_left_d;
      cand_fill_q <= cand_fill_d;
      cand_col_q  <= cand_col_d;
    end
    if (load) begin
      out_col_q <= fail ? '0 : cand_col_q;
      out_row_q <= fail ? '0 : row_full[COORD_BITS-1:0];
      out_oos_q <= fail;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.column_index = out_col_q;
  assign rsp.row_slot     = out_row_q;
  assign rsp.out_of_space = out_oos_q;

  `CAA_ASSERT_NEXT(a_req_starts_div, clk_i, rst_ni, req_fire, state_q == S_DIV, "request did not start the divider")
  `CAA_ASSERT_NOW(a_done_in_div, clk_i, rst_ni, div_done, state_q == S_DIV, "divider finished outside the divide step")
  `CAA_ASSERT_NEXT(a_cursor_hold, clk_i, rst_ni, !load, $stable(col_q) && $stable(fill_q) && $stable(left_q), "cursor moved without a placement")
  `CAA_ASSERT_NOW(a_oos_zero, clk_i, rst_ni, out_valid_q && out_oos_q, out_col_q == '0 && out_row_q == '0, "failed allocation carries nonzero coordinates")

endmodule

`default_nettype wire

// File: design/caa_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: one quotient bit per cycle, MSB first
module caa_div #(
  parameter int DIVIDEND_W = caa_pkg::COUNT_BITS_DEF + 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [DIVIDEND_W-1:0]         dividend_i,
  input  wire logic [caa_pkg::ITEM_W-1:0]    divisor_i,
  output logic                               done_o,
  output logic [DIVIDEND_W-1:0]              quotient_o
);

  localparam int CW = $clog2(DIVIDEND_W + 1);
  localparam int IW = caa_pkg::ITEM_W;

  logic [CW-1:0]         cnt_q;
  logic                  done_q;
  logic [DIVIDEND_W-1:0] shreg_q;
  logic [IW-1:0]         rem_q;
  logic [IW-1:0]         divisor_q;

  logic [IW:0] trial;
  logic [IW:0] diff;
  logic        take;

  // Bring down the next dividend bit and try a subtract
  always_comb begin
    trial = {rem_q, shreg_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor_q};
    take  = (trial >= {1'b0, divisor_q});
  end

  // Count steps, flag the cycle after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(DIVIDEND_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Shift dividend out, quotient in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q   <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (cnt_q != '0) begin
      shreg_q <= {shreg_q[DIVIDEND_W-2:0], take};
      rem_q   <= take ? diff[IW-1:0] : trial[IW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shreg_q;

endmodule

`default_nettype wire
